>>> hw/rtl/cle_pkg.sv
package cle_pkg;

    // default store depth
    localparam int DEPTH_DEF = 256;

    // field widths fixed by the item format
    localparam int KIND_W  = 3;
    localparam int INDEX_W = 8;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 9;
    localparam int BASE_W  = 8;

    // operation kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ      = 3'd0,
        KIND_OVERWRITE = 3'd1,
        KIND_INSERT    = 3'd2,
        KIND_APPEND    = 3'd3,
        KIND_DELETE    = 3'd4,
        KIND_DROP      = 3'd5
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_MOVE_CHK,
        S_MOVE_WR,
        S_FINISH
    } state_t;

    // read address select
    typedef enum logic {
        RD_ITEM,
        RD_MOVE
    } rd_sel_t;

    // write address / data select
    typedef enum logic [1:0] {
        WR_ITEM,
        WR_APPEND,
        WR_MOVE
    } wr_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    ptr_init;
        logic    ptr_step;
        logic    count_inc;
        logic    count_dec;
        logic    res_load;
        status_t res_status;
        logic    res_rd_ok;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        kind_t kind;
        logic  in_list;
        logic  full;
        logic  empty;
        logic  move_more;
    } dp_status_t;

endpackage

>>> hw/rtl/cle_ram.sv
module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/cle_datapath.sv
module cle_datapath #(
    parameter int DEPTH = cle_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item fields
    input  logic [cle_pkg::KIND_W-1:0]    in_kind,
    input  logic [cle_pkg::INDEX_W-1:0]   in_index,
    input  logic [cle_pkg::VALUE_W-1:0]   in_value,
    // base register write
    input  logic                          cfg_we,
    input  logic [cle_pkg::BASE_W-1:0]    cfg_data,
    // control
    input  cle_pkg::dp_cmd_t              cmd,
    output cle_pkg::dp_status_t           sts,
    // result payload
    output logic [cle_pkg::VALUE_W-1:0]   res_read_value,
    output cle_pkg::status_t              res_status,
    output logic [cle_pkg::LEN_W-1:0]     res_length
);

    import cle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

    logic [KIND_W-1:0]  kind_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [EW-1:0]      ptr_reg;
    logic [EW-1:0]      ptr_next;
    logic               src_oob_reg;
    logic [VALUE_W-1:0] rv_reg;
    status_t            st_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [EW-1:0]      idx_e;
    logic [EW-1:0]      base_e;
    logic [EW-1:0]      end_e;
    logic [EW-1:0]      depth_e;
    logic [EW-1:0]      src_e;
    logic [EW-1:0]      rd_addr_e;
    logic [EW-1:0]      wr_addr_e;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W-1:0] ram_rdata;
    logic               ram_we;
    logic               is_ins;

    // list bounds and checks
    always_comb
    begin
        idx_e   = EW'(idx_reg);
        base_e  = EW'(base_reg);
        end_e   = base_e + EW'(count_reg);
        depth_e = EW'(DEPTH);
        is_ins  = (kind_t'(kind_reg) == KIND_INSERT);
        src_e   = is_ins ? (ptr_reg - EW'(1)) : (ptr_reg + EW'(1));
    end

    assign sts.kind      = kind_t'(kind_reg);
    assign sts.in_list   = (count_reg != '0) && (idx_e >= base_e) && (idx_e < end_e)
                           && (idx_e < depth_e);
    assign sts.full      = (end_e >= depth_e);
    assign sts.empty     = (count_reg == '0);
    assign sts.move_more = is_ins ? (ptr_reg > idx_e) : ((ptr_reg + EW'(1)) < end_e);

    // store address and data muxing
    always_comb
    begin
        rd_addr_e = (cmd.rd_sel == RD_MOVE) ? src_e : idx_e;
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_addr_e = end_e;
                wr_data   = val_reg;
            end
            WR_MOVE:
            begin
                wr_addr_e = ptr_reg;
                wr_data   = src_oob_reg ? '0 : ram_rdata;
            end
            default:
            begin
                wr_addr_e = idx_e;
                wr_data   = val_reg;
            end
        endcase
        // slots past the end of the store are dropped
        ram_we = cmd.wr_en && (wr_addr_e < depth_e);
    end

    cle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_e[AW-1:0]),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr_e[AW-1:0]),
        .rdata (ram_rdata)
    );

    // move pointer and count next values
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_init)
        begin
            ptr_next = is_ins ? end_e : idx_e;
        end
        else if (cmd.ptr_step)
        begin
            ptr_next = src_e;
        end

        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    // item capture, move pointer, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            idx_reg  <= in_index;
            val_reg  <= in_value;
        end
        ptr_reg <= ptr_next;
        if (cmd.rd_en)
        begin
            src_oob_reg <= (rd_addr_e >= depth_e);
        end
        if (cmd.res_load)
        begin
            rv_reg  <= cmd.res_rd_ok ? ram_rdata : '0;
            st_reg  <= cmd.res_status;
            len_reg <= LEN_W'(count_reg);
        end
    end

    assign res_read_value = rv_reg;
    assign res_status     = st_reg;
    assign res_length     = len_reg;

    // count only moves on a command
    a_count_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(cmd.count_inc || cmd.count_dec))
        else $error("entry count changed without a command");

    // list never outgrows the store
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.count_inc) |-> (count_reg < CW'(DEPTH)))
        else $error("entry count grew past depth");

endmodule

>>> hw/rtl/cle_ctrl.sv
module cle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  cle_pkg::dp_status_t   sts,
    output cle_pkg::dp_cmd_t      cmd
);

    import cle_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;
    logic    rd_ok_reg;
    logic    rd_ok_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    // next state
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = STAT_OK;
                rd_ok_next  = 1'b0;
                state_next  = S_FINISH;
                case (sts.kind)
                    KIND_READ:
                    begin
                        if (sts.in_list)
                        begin
                            rd_ok_next = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            status_next = STAT_RANGE;
                        end
                    end
                    KIND_OVERWRITE, KIND_DELETE:
                    begin
                        if (!sts.in_list)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else if (sts.kind == KIND_DELETE)
                        begin
                            state_next = S_MOVE_CHK;
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (sts.full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (!sts.in_list)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            state_next = S_MOVE_CHK;
                        end
                    end
                    KIND_APPEND:
                    begin
                        if (sts.full)
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    KIND_DROP:
                    begin
                        if (sts.empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_MOVE_CHK:
            begin
                state_next = sts.move_more ? S_MOVE_WR : S_FINISH;
            end
            S_MOVE_WR:
            begin
                state_next = S_MOVE_CHK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_ITEM;
        cmd.wr_sel = WR_ITEM;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE:
            begin
                case (sts.kind)
                    KIND_READ:
                    begin
                        cmd.rd_en = sts.in_list;
                    end
                    KIND_OVERWRITE:
                    begin
                        cmd.wr_en = sts.in_list;
                    end
                    KIND_INSERT:
                    begin
                        cmd.ptr_init = !sts.full && sts.in_list;
                    end
                    KIND_APPEND:
                    begin
                        cmd.wr_en     = !sts.full;
                        cmd.wr_sel    = WR_APPEND;
                        cmd.count_inc = !sts.full;
                    end
                    KIND_DELETE:
                    begin
                        cmd.ptr_init = sts.in_list;
                    end
                    KIND_DROP:
                    begin
                        cmd.count_dec = !sts.empty;
                    end
                    default:
                    begin
                        cmd.capture = 1'b0;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                cmd.capture = 1'b0;
            end
            S_MOVE_CHK:
            begin
                if (sts.move_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MOVE;
                end
                else if (sts.kind == KIND_INSERT)
                begin
                    // gap is open: drop the new word in
                    cmd.wr_en     = 1'b1;
                    cmd.count_inc = 1'b1;
                end
                else
                begin
                    cmd.count_dec = 1'b1;
                end
            end
            S_MOVE_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_MOVE;
                cmd.ptr_step = 1'b1;
            end
            S_FINISH:
            begin
                cmd.res_load   = !out_valid_reg || m_tready;
                cmd.res_status = status_reg;
                cmd.res_rd_ok  = rd_ok_reg;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

    // output item valid
    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= STAT_OK;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // each write of a move follows its read
    a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE_WR) |-> ($past(state_reg) == S_MOVE_CHK))
        else $error("move write without a preceding read");

    // read data wait only after a decoded read
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ_WAIT) |-> ($past(state_reg) == S_DECODE && rd_ok_reg))
        else $error("read wait entered out of order");

endmodule

>>> hw/rtl/contiguous_list_engine_top.sv
// Contiguous list engine: keeps an ordered list of 32-bit words in a DEPTH-slot
// store, starting at slot base_index (cfg_data, written with cfg_we while idle;
// the block does not enforce this). Each input item is one operation (read,
// overwrite, insert before, append, delete at, drop last) and gives exactly one
// result item with status and the new length. Items are worked one at a time
// through a single store with one write and one registered read port: a failing
// operation, overwrite, append, drop or an unused kind goes from decode straight
// to finish, a read also waits for the store data, and insert and delete move
// the entries that shift one by one, each with one store read and one store
// write. A finished result sits in the output register while the next item
// is accepted. The store has no reset; the list length resets to zero.
module contiguous_list_engine_top #(
    parameter int DEPTH = cle_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // base register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,     // base_index
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,      // [7:0] index, [39:8] value
    input  logic [2:0]  s_tuser,      // [2:0] kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // [31:0] read_value, [40:32] length, rest zero
    output logic [1:0]  m_tuser       // [1:0] status
);

    import cle_pkg::*;

    dp_cmd_t             cmd;
    dp_status_t          sts;
    logic [VALUE_W-1:0]  res_read_value;
    status_t             res_status;
    logic [LEN_W-1:0]    res_length;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_kind        (s_tuser),
        .in_index       (s_tdata[7:0]),
        .in_value       (s_tdata[39:8]),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .sts            (sts),
        .res_read_value (res_read_value),
        .res_status     (res_status),
        .res_length     (res_length)
    );

    assign m_tdata = {7'd0, res_length, res_read_value};
    assign m_tuser = res_status;

endmodule

>>> sim/tb.sv
module tb;
    import cle_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int N_ITEMS    = 1750;
    localparam int LIMIT      = 5_000_000;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE_LEN = 8;

    // kinds the block treats as no operation
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    // mix of operations in a phase
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } list_op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        status_t            status;
        logic [LEN_W-1:0]   length;
    } list_res_t;

    typedef struct {
        list_op_t  op;
        list_res_t res;
        int        gap;
    } op_job_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata = '0;   // [7:0] index, [39:8] value
    logic [2:0]         s_tuser = '0;   // [2:0] kind
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;        // [31:0] read_value, [40:32] length
    logic [1:0]         m_tuser;        // [1:0] status

    // shadow of the list
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    int                 list_len = 0;
    int                 list_base = 0;

    op_job_t            ops_to_send [$];
    list_res_t          results_due [$];
    op_job_t            cur_job;
    bit                 have_cur = 1'b0;
    int                 tx_wait = 0;
    bit                 tx_idle = 1'b1;
    bit                 rx_idle = 1'b1;
    int                 rx_wait = 0;
    int                 hold_left = 0;
    int                 hold_at = 100;
    int                 ops_built = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;

    contiguous_list_engine_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // slots past the store read as zero and swallow writes
    function automatic logic [VALUE_W-1:0] slot_rd(input int i);
        return (i < DEPTH) ? shadow_store[i] : '0;
    endfunction

    function automatic void slot_wr(input int i, input logic [VALUE_W-1:0] v);
        if (i < DEPTH)
            shadow_store[i] = v;
    endfunction

    // apply one operation to the shadow list, return its result
    function automatic list_res_t list_apply(input list_op_t op);
        list_res_t r;
        int        idx;
        int        i;
        bit        hit;
        bit        full;
        r    = '0;
        idx  = op.index;
        hit  = list_len > 0 && idx >= list_base && idx < list_base + list_len && idx < DEPTH;
        full = list_base + list_len >= DEPTH;
        case (op.kind)
            KIND_READ:
                if (hit)
                    r.read_value = slot_rd(idx);
                else
                    r.status = STAT_RANGE;
            KIND_OVERWRITE:
                if (hit)
                    slot_wr(idx, op.value);
                else
                    r.status = STAT_RANGE;
            KIND_INSERT:
                if (full)
                    r.status = STAT_FULL;
                else if (!hit)
                    r.status = STAT_RANGE;
                else
                begin
                    // shift tail up, top entry first
                    for (i = list_base + list_len; i > idx; i--)
                        slot_wr(i, slot_rd(i - 1));
                    slot_wr(idx, op.value);
                    list_len++;
                end
            KIND_APPEND:
                if (full)
                    r.status = STAT_FULL;
                else
                begin
                    slot_wr(list_base + list_len, op.value);
                    list_len++;
                end
            KIND_DELETE:
                if (!hit)
                    r.status = STAT_RANGE;
                else
                begin
                    // close the gap
                    for (i = idx; i + 1 < list_base + list_len; i++)
                        slot_wr(i, slot_rd(i + 1));
                    list_len--;
                end
            KIND_DROP:
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                    list_len--;
            default:
                ;
        endcase
        r.length = LEN_W'(list_len);
        return r;
    endfunction

    task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] index,
                            input logic [VALUE_W-1:0] value);
        op_job_t j;
        j.op.kind  = kind;
        j.op.index = index;
        j.op.value = value;
        j.res      = list_apply(j.op);
        j.gap      = tx_idle ? $urandom_range(0, 7) : 0;
        ops_to_send.push_back(j);
        ops_built++;
    endtask

    // wait until the block has drained and gone quiet
    task automatic settle();
        while (ops_to_send.size() != 0 || have_cur || results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_LEN) @(negedge clk);
    endtask

    task automatic set_base(input logic [BASE_W-1:0] b);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= b;
        @(posedge clk);
        cfg_we   <= 1'b0;
        list_base = b;
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int mix);
        int r;
        int g;
        int s;
        r = $urandom_range(0, 99);
        g = (mix == MIX_GROW) ? 30 : (mix == MIX_SHRINK) ? 5 : 17;
        s = (mix == MIX_SHRINK) ? 30 : (mix == MIX_GROW) ? 5 : 17;
        if (r < 15)
            return KIND_READ;
        if (r < 25)
            return KIND_OVERWRITE;
        if (r < 25 + g)
            return KIND_INSERT;
        if (r < 25 + 2 * g)
            return KIND_APPEND;
        if (r < 25 + 2 * g + s)
            return KIND_DELETE;
        if (r < 25 + 2 * g + 2 * s)
            return KIND_DROP;
        return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    endfunction

    // mostly inside the list, some at its edges, some anywhere
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        int span;
        r    = $urandom_range(0, 99);
        span = (list_len < DEPTH - list_base) ? list_len : DEPTH - list_base;
        if (r < 80 && span > 0)
            return INDEX_W'(list_base + $urandom_range(0, span - 1));
        if (r < 90)
            return $urandom_range(0, 1) ? INDEX_W'(list_base + list_len)
                                        : INDEX_W'(list_base - 1);
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    // stimulus
    initial
    begin
        int mix;
        int n;
        int b;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_base(8'd0);

        // empty list corner cases
        queue_op(KIND_READ, 8'd0, 32'h0);
        queue_op(KIND_OVERWRITE, 8'd0, 32'h1);
        queue_op(KIND_INSERT, 8'd0, 32'h2);
        queue_op(KIND_DELETE, 8'd0, 32'h0);
        queue_op(KIND_DROP, 8'd0, 32'h0);
        queue_op(KIND_SPARE_A, 8'd255, 32'hFFFF_FFFF);
        queue_op(KIND_SPARE_B, 8'd0, 32'h0);
        // build a short list and work on it
        queue_op(KIND_APPEND, 8'd255, 32'hFFFF_FFFF);
        queue_op(KIND_APPEND, 8'd0, 32'h0);
        queue_op(KIND_APPEND, 8'd7, 32'h1234_5678);
        queue_op(KIND_INSERT, 8'd0, 32'hA5A5_A5A5);
        queue_op(KIND_INSERT, 8'd3, 32'h5A5A_5A5A);
        queue_op(KIND_READ, 8'd0, 32'h0);
        queue_op(KIND_READ, 8'd4, 32'h0);
        queue_op(KIND_READ, 8'd5, 32'h0);
        queue_op(KIND_OVERWRITE, 8'd1, 32'hDEAD_BEEF);
        queue_op(KIND_READ, 8'd1, 32'h0);
        queue_op(KIND_DELETE, 8'd0, 32'h0);
        queue_op(KIND_DELETE, 8'd3, 32'h0);
        queue_op(KIND_READ, 8'd255, 32'h0);
        repeat (4) queue_op(KIND_DROP, 8'd0, 32'h0);

        // fill the whole store so no slot stays unwritten, then hit full
        while (list_len < DEPTH)
            queue_op(KIND_APPEND, INDEX_W'($urandom_range(0, 255)), rand_word());
        queue_op(KIND_APPEND, 8'd0, rand_word());
        queue_op(KIND_INSERT, 8'd0, rand_word());
        queue_op(KIND_INSERT, 8'd200, rand_word());
        queue_op(KIND_READ, 8'd255, 32'h0);
        queue_op(KIND_DELETE, 8'd0, 32'h0);
        queue_op(KIND_INSERT, 8'd0, rand_word());

        // random phases, each under its own base
        while (ops_built < N_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 5))
                0:       b = 0;
                1:       b = 255;
                2:       b = (list_len == 0) ? 255 : DEPTH - list_len;
                3:       b = $urandom_range(0, 255);
                4:       b = $urandom_range(0, 15);
                default: b = list_base;
            endcase
            if (b > 255)
                b = 255;
            if (b < 0)
                b = 0;
            set_base(BASE_W'(b));
            tx_idle  = ($urandom_range(0, 3) != 0);
            rx_idle <= ($urandom_range(0, 3) != 0);
            mix      = $urandom_range(MIX_GROW, MIX_EVEN);
            n        = $urandom_range(60, 220);
            repeat (n) queue_op(pick_kind(mix), pick_index(), rand_word());
        end

        // drain and let the block go quiet
        while (ops_to_send.size() != 0 || have_cur)
            @(negedge clk);
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            have_cur = 1'b0;
            tx_wait  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                results_due.push_back(cur_job.res);
                have_cur = 1'b0;
            end
            if (!have_cur && ops_to_send.size() != 0)
            begin
                cur_job  = ops_to_send.pop_front();
                have_cur = 1'b1;
                tx_wait  = cur_job.gap;
            end
            if (have_cur && tx_wait == 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_job.op.value, cur_job.op.index};
                s_tuser  <= cur_job.op.kind;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (have_cur)
                    tx_wait--;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        list_res_t want;
        list_res_t seen;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.read_value = m_tdata[31:0];
                seen.length     = m_tdata[40:32];
                seen.status     = status_t'(m_tuser);
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected item, got value %h status %0d length %0d",
                             $time, seen.read_value, seen.status, seen.length);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (seen.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h got %h",
                                 $time, want.read_value, seen.read_value);
                        mismatches++;
                    end
                    if (seen.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, seen.status);
                        mismatches++;
                    end
                    if (seen.length !== want.length)
                    begin
                        $display("%0t: length expected %0d got %0d",
                                 $time, want.length, seen.length);
                        mismatches++;
                    end
                end
                results_seen++;
                rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
            end
            // long back-pressure while the sender still has items
            if (results_seen >= hold_at && ops_to_send.size() > 8)
            begin
                hold_left = HOLD_LEN;
                hold_at   = results_seen + 700;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("%0t: timeout, %0d items still expected", $time, results_due.size());
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
